>>> src/page_lcd_controller_pixel_rmw_defines.svh
// Assertion macros shared by the LCD controller checker.
`ifndef PAGE_LCD_CONTROLLER_PIXEL_RMW_DEFINES_SVH
`define PAGE_LCD_CONTROLLER_PIXEL_RMW_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PLCD_ASSERT_SAME(lbl, clk, dis, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (dis) (ante) |-> (cons)) \
        else $error("plcd checker: same-cycle property failed");

// The consequent must hold in the cycle after the antecedent.
`define PLCD_ASSERT_NEXT(lbl, clk, dis, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (dis) (ante) |=> (cons)) \
        else $error("plcd checker: next-cycle property failed");

`endif

>>> src/plcd_pkg.sv
// Shared types and constants of the page-mode LCD controller.
`timescale 1ns / 1ps

package plcd_pkg;

    // Default display geometry.
    localparam int unsigned PAGES_DEF   = 8;
    localparam int unsigned COLUMNS_DEF = 128;

    // Bus access kinds carried on the input tuser.
    typedef enum logic [2:0] {
        CMD_WRITE_INSTR = 3'd0,
        CMD_WRITE_DATA  = 3'd1,
        CMD_READ_DATA   = 3'd2,
        CMD_READ_STATUS = 3'd3,
        CMD_PIXEL       = 3'd4
    } cmd_t;

    // Pixel operations; the remaining codes clear the pixel.
    localparam logic [1:0] POP_SET    = 2'd1;
    localparam logic [1:0] POP_INVERT = 2'd2;

    // Which operand the next instruction byte carries.
    typedef enum logic [1:0] {
        PEND_NONE  = 2'd0,
        PEND_REF   = 2'd1,
        PEND_IND   = 2'd2
    } pend_t;

    // Instruction byte ranges.
    localparam logic [7:0] INS_COL_LO        = 8'h00;
    localparam logic [7:0] INS_COL_LO_LAST   = 8'h0F;
    localparam logic [7:0] INS_COL_HI        = 8'h10;
    localparam logic [7:0] INS_COL_HI_LAST   = 8'h1F;
    localparam logic [7:0] INS_REGULATOR     = 8'h20;
    localparam logic [7:0] INS_REGULATOR_LAST = 8'h27;
    localparam logic [7:0] INS_POWER         = 8'h28;
    localparam logic [7:0] INS_POWER_LAST    = 8'h2F;
    localparam logic [7:0] INS_START         = 8'h40;
    localparam logic [7:0] INS_START_LAST    = 8'h7F;
    localparam logic [7:0] INS_REF_LEVEL     = 8'h81;
    localparam logic [7:0] INS_ADC           = 8'hA0;
    localparam logic [7:0] INS_ADC_LAST      = 8'hA1;
    localparam logic [7:0] INS_BIAS          = 8'hA2;
    localparam logic [7:0] INS_BIAS_LAST     = 8'hA3;
    localparam logic [7:0] INS_ENTIRE        = 8'hA4;
    localparam logic [7:0] INS_ENTIRE_LAST   = 8'hA5;
    localparam logic [7:0] INS_REVERSE       = 8'hA6;
    localparam logic [7:0] INS_REVERSE_LAST  = 8'hA7;
    localparam logic [7:0] INS_INDICATOR     = 8'hAC;
    localparam logic [7:0] INS_INDICATOR_LAST = 8'hAD;
    localparam logic [7:0] INS_ON            = 8'hAE;
    localparam logic [7:0] INS_ON_LAST       = 8'hAF;
    localparam logic [7:0] INS_PAGE          = 8'hB0;
    localparam logic [7:0] INS_PAGE_LAST     = 8'hBF;
    localparam logic [7:0] INS_SHL           = 8'hC0;
    localparam logic [7:0] INS_SHL_LAST      = 8'hCF;
    localparam logic [7:0] INS_MODIFY_SET    = 8'hE0;
    localparam logic [7:0] INS_SOFT_RESET    = 8'hE2;
    localparam logic [7:0] INS_MODIFY_RESET  = 8'hEE;

    // Bit positions in the mode flags.
    localparam int unsigned FLAG_ON      = 0;
    localparam int unsigned FLAG_ADC     = 1;
    localparam int unsigned FLAG_REVERSE = 2;
    localparam int unsigned FLAG_ENTIRE  = 3;
    localparam int unsigned FLAG_BIAS    = 4;
    localparam int unsigned FLAG_SHL     = 5;

    // Reference level after reset.
    localparam logic [5:0] REF_LEVEL_RESET = 6'd32;

endpackage

>>> src/page_lcd_controller_pixel_rmw.sv
// Top level of the page-mode monochrome LCD controller with pixel engine.
`timescale 1ns / 1ps

// Bus side of a page-organized monochrome LCD controller. Each input transfer
// is one bus access (instruction write, data write, data read, status read or
// pixel operation) and yields exactly one result transfer. The display memory
// is a single-port synchronous RAM of PAGES*COLUMNS bytes. Instruction writes,
// data writes, status reads and out-of-range pixels are answered directly; data
// reads and in-range pixels go through ST_MEM, as the registered RAM read
// precedes the latch update or the write back of the modified byte. After reset
// the RAM is cleared one byte per cycle (1024 bytes at the default geometry),
// while s_tready stays low. Results pass through a result stage and an output
// register, so one item can be accepted while a result waits.
module page_lcd_controller_pixel_rmw #(
    parameter int unsigned PAGES   = plcd_pkg::PAGES_DEF,
    parameter int unsigned COLUMNS = plcd_pkg::COLUMNS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    // Input channel
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // bus_byte[7:0], pixel_x[15:8], pixel_y[23:16],
                                   // pixel_op[25:24], zero fill above
    input  logic [2:0]  s_tuser,   // command[2:0]
    // Result channel
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // read_data[7:0]
    output logic [0:0]  m_tuser    // range_error[0]
);

    localparam int unsigned DEPTH  = PAGES * COLUMNS;
    localparam int unsigned ADDR_W = $clog2(DEPTH);
    localparam int unsigned CALC_W = ADDR_W + 1;

    localparam logic [4:0]        PAGES_LIM = 5'(PAGES);
    localparam logic [8:0]        COLS_LIM  = 9'(COLUMNS);
    localparam logic [8:0]        ROWS_LIM  = 9'(PAGES * 8);
    localparam logic [CALC_W-1:0] COLS_C    = CALC_W'(COLUMNS);
    localparam logic [ADDR_W-1:0] CLR_LAST  = ADDR_W'(DEPTH - 1);

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MEM
    } state_t;

    // Input payload fields.
    plcd_pkg::cmd_t in_cmd;
    logic [7:0]     in_byte;
    logic [7:0]     in_x;
    logic [7:0]     in_y;
    logic [1:0]     in_op;

    assign in_cmd  = plcd_pkg::cmd_t'(s_tuser);
    assign in_byte = s_tdata[7:0];
    assign in_x    = s_tdata[15:8];
    assign in_y    = s_tdata[23:16];
    assign in_op   = s_tdata[25:24];

    // Sequencer and work-item registers.
    state_t              state_reg;
    logic [ADDR_W-1:0]   clr_cnt_reg;
    logic [ADDR_W-1:0]   addr_reg;
    logic                op_read_reg;
    logic                op_addr_ok_reg;
    logic [2:0]          pix_bit_reg;
    logic [1:0]          pix_op_reg;

    // Result stage and output register.
    logic       res_valid_reg;
    logic [7:0] res_data_reg;
    logic       res_err_reg;
    logic       m_tvalid_reg;
    logic [7:0] m_tdata_reg;
    logic       m_tuser_reg;

    // Controller registers.
    logic [3:0]      page_ptr_reg,   page_ptr_next;
    logic [7:0]      col_ptr_reg,    col_ptr_next;
    logic [7:0]      saved_col_reg,  saved_col_next;
    logic            mread_reg,      mread_next;
    logic [7:0]      latch_reg;
    logic [5:0]      mode_reg,       mode_next;
    logic [5:0]      start_line_reg, start_line_next;
    logic [5:0]      ref_level_reg,  ref_level_next;
    logic [5:0]      power_reg,      power_next;
    logic [2:0]      ind_reg,        ind_next;
    plcd_pkg::pend_t pend_reg,       pend_next;

    // Display memory.
    logic [7:0]        mem [DEPTH];
    logic [7:0]        rd_data_reg;
    logic [ADDR_W-1:0] mem_addr;
    logic              mem_we;
    logic [7:0]        mem_wdata;

    logic              accept;
    logic              res_move;
    logic              res_free;
    logic              res_load;
    logic              cur_ok;
    logic              pix_bad;
    logic [ADDR_W-1:0] cur_addr;
    logic [ADDR_W-1:0] pix_addr;
    logic [7:0]        pix_mask;
    logic [7:0]        pix_byte;
    logic [7:0]        status_byte;

    // Handshake and result movement.
    assign res_move = res_valid_reg && (!m_tvalid_reg || m_tready);
    assign res_free = !res_valid_reg || res_move;
    assign s_tready = (state_reg == ST_IDLE) && res_free;
    assign accept   = s_tvalid && s_tready;

    // A new result enters the result stage: at the end of a memory access, or
    // directly for an accepted access that needs no memory read.
    assign res_load = (state_reg == ST_MEM) ||
                      (accept && (in_cmd != plcd_pkg::CMD_READ_DATA) &&
                       !((in_cmd == plcd_pkg::CMD_PIXEL) && !pix_bad));

    assign m_tvalid   = m_tvalid_reg;
    assign m_tdata    = m_tdata_reg;
    assign m_tuser[0] = m_tuser_reg;

    // Cursor and pixel addressing.
    assign cur_ok   = ({1'b0, page_ptr_reg} < PAGES_LIM) && ({1'b0, col_ptr_reg} < COLS_LIM);
    assign cur_addr = ADDR_W'(CALC_W'(page_ptr_reg) * COLS_C + CALC_W'(col_ptr_reg));
    assign pix_bad  = ({1'b0, in_x} >= COLS_LIM) || ({1'b0, in_y} >= ROWS_LIM);
    assign pix_addr = ADDR_W'(CALC_W'(in_y[7:3]) * COLS_C + CALC_W'(in_x));

    // Pixel modify on the byte read back from memory.
    assign pix_mask = 8'd1 << pix_bit_reg;
    always_comb begin
        case (pix_op_reg)
            plcd_pkg::POP_SET:    pix_byte = rd_data_reg | pix_mask;
            plcd_pkg::POP_INVERT: pix_byte = rd_data_reg ^ pix_mask;
            default:              pix_byte = rd_data_reg & ~pix_mask;
        endcase
    end

    assign status_byte = {1'b0, mode_reg[plcd_pkg::FLAG_ADC], mode_reg[plcd_pkg::FLAG_ON], 5'd0};

    // Memory port control: clearing pass, bus accesses, pixel write back.
    always_comb begin
        mem_addr  = cur_addr;
        mem_we    = 1'b0;
        mem_wdata = in_byte;
        case (state_reg)
            ST_CLEAR: begin
                mem_addr  = clr_cnt_reg;
                mem_we    = 1'b1;
                mem_wdata = 8'd0;
            end
            ST_IDLE: begin
                if (in_cmd == plcd_pkg::CMD_PIXEL) begin
                    mem_addr = pix_addr;
                end
                mem_we = accept && (in_cmd == plcd_pkg::CMD_WRITE_DATA) && cur_ok;
            end
            ST_MEM: begin
                mem_addr  = addr_reg;
                mem_we    = !op_read_reg;
                mem_wdata = pix_byte;
            end
            default: begin
                mem_we = 1'b0;
            end
        endcase
    end

    // Synchronous single-port RAM with registered read data.
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_addr] <= mem_wdata;
        end
        rd_data_reg <= mem[mem_addr];
    end

    // Next values of the controller registers for an accepted access.
    always_comb begin
        page_ptr_next   = page_ptr_reg;
        col_ptr_next    = col_ptr_reg;
        saved_col_next  = saved_col_reg;
        mread_next      = mread_reg;
        mode_next       = mode_reg;
        start_line_next = start_line_reg;
        ref_level_next  = ref_level_reg;
        power_next      = power_reg;
        ind_next        = ind_reg;
        pend_next       = pend_reg;
        case (in_cmd)
            plcd_pkg::CMD_WRITE_INSTR: begin
                if (pend_reg == plcd_pkg::PEND_REF) begin
                    // Operand byte of the reference level command.
                    ref_level_next = in_byte[5:0];
                    pend_next      = plcd_pkg::PEND_NONE;
                end else if (pend_reg != plcd_pkg::PEND_NONE) begin
                    // Operand byte of the static indicator command.
                    ind_next  = {in_byte[1:0], ind_reg[0]};
                    pend_next = plcd_pkg::PEND_NONE;
                end else begin
                    case (in_byte) inside
                        [plcd_pkg::INS_COL_LO : plcd_pkg::INS_COL_LO_LAST]:
                            col_ptr_next = {col_ptr_reg[7:4], in_byte[3:0]};
                        [plcd_pkg::INS_COL_HI : plcd_pkg::INS_COL_HI_LAST]:
                            col_ptr_next = {in_byte[3:0], col_ptr_reg[3:0]};
                        [plcd_pkg::INS_REGULATOR : plcd_pkg::INS_REGULATOR_LAST]:
                            power_next = {in_byte[2:0], power_reg[2:0]};
                        [plcd_pkg::INS_POWER : plcd_pkg::INS_POWER_LAST]:
                            power_next = {power_reg[5:3], in_byte[2:0]};
                        [plcd_pkg::INS_START : plcd_pkg::INS_START_LAST]:
                            start_line_next = in_byte[5:0];
                        plcd_pkg::INS_REF_LEVEL:
                            pend_next = plcd_pkg::PEND_REF;
                        [plcd_pkg::INS_ADC : plcd_pkg::INS_ADC_LAST]:
                            mode_next[plcd_pkg::FLAG_ADC] = in_byte[0];
                        [plcd_pkg::INS_BIAS : plcd_pkg::INS_BIAS_LAST]:
                            mode_next[plcd_pkg::FLAG_BIAS] = in_byte[0];
                        [plcd_pkg::INS_ENTIRE : plcd_pkg::INS_ENTIRE_LAST]:
                            mode_next[plcd_pkg::FLAG_ENTIRE] = in_byte[0];
                        [plcd_pkg::INS_REVERSE : plcd_pkg::INS_REVERSE_LAST]:
                            mode_next[plcd_pkg::FLAG_REVERSE] = in_byte[0];
                        [plcd_pkg::INS_INDICATOR : plcd_pkg::INS_INDICATOR_LAST]: begin
                            ind_next  = {ind_reg[2:1], in_byte[0]};
                            pend_next = plcd_pkg::PEND_IND;
                        end
                        [plcd_pkg::INS_ON : plcd_pkg::INS_ON_LAST]:
                            mode_next[plcd_pkg::FLAG_ON] = in_byte[0];
                        [plcd_pkg::INS_PAGE : plcd_pkg::INS_PAGE_LAST]:
                            page_ptr_next = in_byte[3:0];
                        [plcd_pkg::INS_SHL : plcd_pkg::INS_SHL_LAST]:
                            mode_next[plcd_pkg::FLAG_SHL] = in_byte[3];
                        plcd_pkg::INS_MODIFY_SET: begin
                            saved_col_next = col_ptr_reg;
                            mread_next     = 1'b1;
                        end
                        plcd_pkg::INS_MODIFY_RESET: begin
                            if (mread_reg) begin
                                col_ptr_next = saved_col_reg;
                                mread_next   = 1'b0;
                            end
                        end
                        plcd_pkg::INS_SOFT_RESET: begin
                            page_ptr_next   = 4'd0;
                            col_ptr_next    = 8'd0;
                            saved_col_next  = 8'd0;
                            mread_next      = 1'b0;
                            mode_next       = 6'd0;
                            start_line_next = 6'd0;
                            ref_level_next  = plcd_pkg::REF_LEVEL_RESET;
                            power_next      = 6'd0;
                            ind_next        = 3'd0;
                            pend_next       = plcd_pkg::PEND_NONE;
                        end
                        default: begin
                            pend_next = pend_reg;
                        end
                    endcase
                end
            end
            plcd_pkg::CMD_WRITE_DATA: begin
                if (({1'b0, col_ptr_reg} + 9'd1) < COLS_LIM) begin
                    col_ptr_next = col_ptr_reg + 8'd1;
                end
            end
            plcd_pkg::CMD_READ_DATA: begin
                if (!mread_reg && (({1'b0, col_ptr_reg} + 9'd1) < COLS_LIM)) begin
                    col_ptr_next = col_ptr_reg + 8'd1;
                end
            end
            default: begin
                pend_next = pend_reg;
            end
        endcase
    end

    // Controller registers and the dummy-read latch.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            page_ptr_reg   <= 4'd0;
            col_ptr_reg    <= 8'd0;
            saved_col_reg  <= 8'd0;
            mread_reg      <= 1'b0;
            latch_reg      <= 8'd0;
            mode_reg       <= 6'd0;
            start_line_reg <= 6'd0;
            ref_level_reg  <= plcd_pkg::REF_LEVEL_RESET;
            power_reg      <= 6'd0;
            ind_reg        <= 3'd0;
            pend_reg       <= plcd_pkg::PEND_NONE;
        end else begin
            if (accept) begin
                page_ptr_reg   <= page_ptr_next;
                col_ptr_reg    <= col_ptr_next;
                saved_col_reg  <= saved_col_next;
                mread_reg      <= mread_next;
                mode_reg       <= mode_next;
                start_line_reg <= start_line_next;
                ref_level_reg  <= ref_level_next;
                power_reg      <= power_next;
                ind_reg        <= ind_next;
                pend_reg       <= pend_next;
            end
            if ((state_reg == ST_MEM) && op_read_reg) begin
                latch_reg <= op_addr_ok_reg ? rd_data_reg : 8'd0;
            end
        end
    end

    // Sequencer, result stage and output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_CLEAR;
            clr_cnt_reg   <= '0;
            res_valid_reg <= 1'b0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            // The result stage drains into the output register.
            if (res_move) begin
                m_tvalid_reg <= 1'b1;
                m_tdata_reg  <= res_data_reg;
                m_tuser_reg  <= res_err_reg;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end

            // A loaded result replaces the one that has just moved on.
            if (res_load) begin
                res_valid_reg <= 1'b1;
            end else if (res_move) begin
                res_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_CLEAR: begin
                    clr_cnt_reg <= clr_cnt_reg + ADDR_W'(1);
                    if (clr_cnt_reg == CLR_LAST) begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (accept) begin
                        case (in_cmd)
                            plcd_pkg::CMD_READ_DATA: begin
                                state_reg      <= ST_MEM;
                                op_read_reg    <= 1'b1;
                                op_addr_ok_reg <= cur_ok;
                                addr_reg       <= cur_addr;
                            end
                            plcd_pkg::CMD_PIXEL: begin
                                if (pix_bad) begin
                                    res_data_reg <= 8'd0;
                                    res_err_reg  <= 1'b1;
                                end else begin
                                    state_reg   <= ST_MEM;
                                    op_read_reg <= 1'b0;
                                    addr_reg    <= pix_addr;
                                    pix_bit_reg <= in_y[2:0];
                                    pix_op_reg  <= in_op;
                                end
                            end
                            plcd_pkg::CMD_READ_STATUS: begin
                                res_data_reg <= status_byte;
                                res_err_reg  <= 1'b0;
                            end
                            default: begin
                                res_data_reg <= 8'd0;
                                res_err_reg  <= 1'b0;
                            end
                        endcase
                    end
                end
                ST_MEM: begin
                    // Data read returns the old latch; pixel writes back now.
                    state_reg    <= ST_IDLE;
                    res_data_reg <= op_read_reg ? latch_reg : 8'd0;
                    res_err_reg  <= 1'b0;
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

>>> src/plcd_checker.sv
// Port-level checker for the LCD controller, bound to the top level.
`timescale 1ns / 1ps
`include "page_lcd_controller_pixel_rmw_defines.svh"

module plcd_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [2:0]  s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [7:0]  m_tdata,
    input logic [0:0]  m_tuser
);

    // A result held back by the sink stays offered.
    `PLCD_ASSERT_NEXT(a_out_hold, aclk, !aresetn, m_tvalid && !m_tready, m_tvalid)

    // Reset starts the clearing pass: nothing accepted, nothing offered.
    `PLCD_ASSERT_NEXT(a_reset_quiet, aclk, 1'b0, !aresetn, !s_tready && !m_tvalid)

    // A data read holds off the next transfer while its memory access completes.
    `PLCD_ASSERT_NEXT(a_read_busy, aclk, !aresetn,
        s_tvalid && s_tready && (s_tuser == plcd_pkg::CMD_READ_DATA), !s_tready)

    // A range error comes only from a pixel access, which returns no data.
    `PLCD_ASSERT_SAME(a_err_no_data, aclk, !aresetn,
        m_tvalid && m_tuser[0], m_tdata == 8'd0)

endmodule

bind page_lcd_controller_pixel_rmw plcd_checker u_plcd_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

>>> verif/page_lcd_controller_pixel_rmw_tb.sv
// Self-checking testbench for the page-mode LCD controller with pixel engine.
`timescale 1ns / 1ps

module page_lcd_controller_pixel_rmw_tb;

    // Display geometry of the instance under test.
    localparam int unsigned PAGES     = plcd_pkg::PAGES_DEF;
    localparam int unsigned COLUMNS   = plcd_pkg::COLUMNS_DEF;
    localparam int unsigned ROWS      = PAGES * 8;
    localparam int unsigned MEM_BYTES = PAGES * COLUMNS;

    // Command codes the block treats as no-ops, and the two clearing pixel codes.
    localparam logic [2:0] CMD_UNDEF_FIRST = 3'd5;
    localparam logic [2:0] CMD_UNDEF_LAST  = 3'd7;
    localparam logic [1:0] POP_CLEAR       = 2'd0;
    localparam logic [1:0] POP_CLEAR_ALT   = 2'd3;

    localparam int unsigned REPORT_LIMIT = 25;
    localparam int unsigned TIMEOUT_NS   = 3_000_000;
    localparam int unsigned PHASE_ITEMS  = 400;

    logic        aclk;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata  = '0;   // bus_byte[7:0], pixel_x[15:8], pixel_y[23:16],
                                  // pixel_op[25:24], zero fill above
    logic [2:0]  s_tuser  = plcd_pkg::CMD_WRITE_INSTR;   // command[2:0]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;         // read_data[7:0]
    logic [0:0]  m_tuser;         // range_error[0]

    int unsigned send_idle_pct;
    int unsigned recv_idle_pct;
    int unsigned sent;

    // One expected result transfer.
    typedef struct {
        logic [7:0]  read_data;
        logic        range_error;
        int unsigned seq;
    } lcd_result_t;

    // Mirror of the controller state; predicts one result per accepted access.
    class display_scoreboard;
        logic [7:0]      mem [MEM_BYTES];
        logic [3:0]      page;
        logic [7:0]      column;
        logic [7:0]      saved_column;
        logic            modify_read;
        logic [7:0]      read_latch;
        logic [5:0]      mode;
        logic [5:0]      start_line;
        logic [5:0]      ref_level;
        logic [5:0]      power_reg;
        logic [2:0]      indicator;
        plcd_pkg::pend_t pending;
        lcd_result_t     expected_q[$];
        int unsigned     accepted;
        int unsigned     checked;
        int unsigned     mismatches;
        int unsigned     per_cmd [8];
        int unsigned     pixel_errors;
        int unsigned     undefined_cmds;

        function new();
            foreach (mem[i]) mem[i] = '0;
            foreach (per_cmd[i]) per_cmd[i] = 0;
            read_latch     = '0;
            accepted       = 0;
            checked        = 0;
            mismatches     = 0;
            pixel_errors   = 0;
            undefined_cmds = 0;
            clear_registers();
        endfunction

        // Everything but memory and the read latch; also the soft reset.
        function void clear_registers();
            page         = '0;
            column       = '0;
            saved_column = '0;
            modify_read  = 1'b0;
            mode         = '0;
            start_line   = '0;
            ref_level    = plcd_pkg::REF_LEVEL_RESET;
            power_reg    = '0;
            indicator    = '0;
            pending      = plcd_pkg::PEND_NONE;
        endfunction

        function bit address_valid();
            return (page < PAGES) && (column < COLUMNS);
        endfunction

        function int unsigned address();
            return int'(page) * COLUMNS + int'(column);
        endfunction

        // The column saturates at the last one.
        function void advance_column();
            if (int'(column) + 1 < COLUMNS) column = column + 8'd1;
        endfunction

        function void decode_instruction(logic [7:0] b);
            if (pending == plcd_pkg::PEND_REF) begin
                ref_level = b[5:0];
                pending   = plcd_pkg::PEND_NONE;
            end else if (pending != plcd_pkg::PEND_NONE) begin
                indicator = {b[1:0], indicator[0]};
                pending   = plcd_pkg::PEND_NONE;
            end else if (b <= plcd_pkg::INS_COL_LO_LAST) begin
                column[3:0] = b[3:0];
            end else if (b <= plcd_pkg::INS_COL_HI_LAST) begin
                column[7:4] = b[3:0];
            end else if (b <= plcd_pkg::INS_REGULATOR_LAST) begin
                power_reg[5:3] = b[2:0];
            end else if (b <= plcd_pkg::INS_POWER_LAST) begin
                power_reg[2:0] = b[2:0];
            end else if (b >= plcd_pkg::INS_START && b <= plcd_pkg::INS_START_LAST) begin
                start_line = b[5:0];
            end else if (b == plcd_pkg::INS_REF_LEVEL) begin
                pending = plcd_pkg::PEND_REF;
            end else if (b[7:1] == plcd_pkg::INS_ADC[7:1]) begin
                mode[plcd_pkg::FLAG_ADC] = b[0];
            end else if (b[7:1] == plcd_pkg::INS_BIAS[7:1]) begin
                mode[plcd_pkg::FLAG_BIAS] = b[0];
            end else if (b[7:1] == plcd_pkg::INS_ENTIRE[7:1]) begin
                mode[plcd_pkg::FLAG_ENTIRE] = b[0];
            end else if (b[7:1] == plcd_pkg::INS_REVERSE[7:1]) begin
                mode[plcd_pkg::FLAG_REVERSE] = b[0];
            end else if (b[7:1] == plcd_pkg::INS_INDICATOR[7:1]) begin
                indicator[0] = b[0];
                pending      = plcd_pkg::PEND_IND;
            end else if (b[7:1] == plcd_pkg::INS_ON[7:1]) begin
                mode[plcd_pkg::FLAG_ON] = b[0];
            end else if (b[7:4] == plcd_pkg::INS_PAGE[7:4]) begin
                page = b[3:0];
            end else if (b[7:4] == plcd_pkg::INS_SHL[7:4]) begin
                mode[plcd_pkg::FLAG_SHL] = b[3];
            end else if (b == plcd_pkg::INS_MODIFY_SET) begin
                saved_column = column;
                modify_read  = 1'b1;
            end else if (b == plcd_pkg::INS_MODIFY_RESET) begin
                if (modify_read) begin
                    column      = saved_column;
                    modify_read = 1'b0;
                end
            end else if (b == plcd_pkg::INS_SOFT_RESET) begin
                clear_registers();
            end
        endfunction

        // Applies one accepted access and queues the result it must produce.
        function void note_access(logic [2:0] cmd, logic [7:0] bus_byte, logic [7:0] px,
                                  logic [7:0] py, logic [1:0] op);
            lcd_result_t r;
            int unsigned a;
            r.read_data   = '0;
            r.range_error = 1'b0;
            r.seq         = accepted;
            case (cmd)
                plcd_pkg::CMD_WRITE_INSTR: decode_instruction(bus_byte);
                plcd_pkg::CMD_WRITE_DATA: begin
                    if (address_valid()) mem[address()] = bus_byte;
                    advance_column();
                end
                plcd_pkg::CMD_READ_DATA: begin
                    // The latch returns what the previous read fetched.
                    r.read_data = read_latch;
                    read_latch  = address_valid() ? mem[address()] : 8'h00;
                    if (!modify_read) advance_column();
                end
                plcd_pkg::CMD_READ_STATUS: begin
                    r.read_data = {1'b0, mode[plcd_pkg::FLAG_ADC], mode[plcd_pkg::FLAG_ON],
                                   5'b00000};
                end
                plcd_pkg::CMD_PIXEL: begin
                    if (px >= COLUMNS || py >= ROWS) begin
                        r.range_error = 1'b1;
                        pixel_errors++;
                    end else begin
                        a = (int'(py) / 8) * COLUMNS + int'(px);
                        case (op)
                            plcd_pkg::POP_SET:    mem[a][py[2:0]] = 1'b1;
                            plcd_pkg::POP_INVERT: mem[a][py[2:0]] = ~mem[a][py[2:0]];
                            default:              mem[a][py[2:0]] = 1'b0;
                        endcase
                    end
                end
                default: undefined_cmds++;
            endcase
            per_cmd[cmd]++;
            accepted++;
            expected_q.push_back(r);
        endfunction

        task report(string msg);
            mismatches++;
            if (mismatches <= REPORT_LIMIT) $display("MISMATCH at %0t: %s", $time, msg);
        endtask

        // Compares one result transfer with the oldest expectation.
        task check_result(logic [7:0] data, logic err);
            lcd_result_t r;
            if (expected_q.size() == 0) begin
                report($sformatf("result %02h/%0b arrived with nothing expected", data, err));
                return;
            end
            r = expected_q.pop_front();
            checked++;
            if (data !== r.read_data)
                report($sformatf("access %0d: read_data %02h, expected %02h",
                                 r.seq, data, r.read_data));
            if (err !== r.range_error)
                report($sformatf("access %0d: range_error %0b, expected %0b",
                                 r.seq, err, r.range_error));
        endtask
    endclass

    display_scoreboard sb = new();

    page_lcd_controller_pixel_rmw dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // Free-running clock.
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Run limit.
    initial begin
        #(TIMEOUT_NS);
        $display("Timeout with %0d results still expected.", sb.expected_q.size());
        $display("page_lcd_controller_pixel_rmw verification failed");
        $finish;
    end

    // Result side: check each transfer and stall at random.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check_result(m_tdata, m_tuser[0]);
        m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // Drives one access and waits for its transfer; each cycle before it the
    // sender may idle.
    task automatic send_access(logic [2:0] cmd, logic [7:0] bus_byte, logic [7:0] px,
                               logic [7:0] py, logic [1:0] op);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {6'b000000, op, py, px, bus_byte};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.note_access(cmd, bus_byte, px, py, op);
        sent++;
    endtask

    // Unused fields carry random values.
    task automatic send_instr(logic [7:0] b);
        send_access(plcd_pkg::CMD_WRITE_INSTR, b, 8'($urandom), 8'($urandom), 2'($urandom));
    endtask

    task automatic send_data(logic [7:0] b);
        send_access(plcd_pkg::CMD_WRITE_DATA, b, 8'($urandom), 8'($urandom), 2'($urandom));
    endtask

    task automatic send_read();
        send_access(plcd_pkg::CMD_READ_DATA, 8'($urandom), 8'($urandom), 8'($urandom),
                    2'($urandom));
    endtask

    task automatic send_status();
        send_access(plcd_pkg::CMD_READ_STATUS, 8'($urandom), 8'($urandom), 8'($urandom),
                    2'($urandom));
    endtask

    task automatic send_pixel(logic [7:0] px, logic [7:0] py, logic [1:0] op);
        send_access(plcd_pkg::CMD_PIXEL, 8'($urandom), px, py, op);
    endtask

    task automatic set_address(logic [3:0] pg, logic [7:0] col);
        send_instr(plcd_pkg::INS_PAGE | {4'h0, pg});
        send_instr(plcd_pkg::INS_COL_HI | {4'h0, col[7:4]});
        send_instr(plcd_pkg::INS_COL_LO | {4'h0, col[3:0]});
    endtask

    // Holds the sender off until every expected result has come back.
    task automatic drain();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (sb.expected_q.size() != 0);
    endtask

    // Mostly in-range addresses, with the last columns and out-of-range ones mixed in.
    function automatic logic [3:0] rand_page();
        return ($urandom_range(0, 9) == 0) ? 4'($urandom_range(0, 15))
                                           : 4'($urandom_range(0, PAGES - 1));
    endfunction

    function automatic logic [7:0] rand_column();
        case ($urandom_range(0, 9))
            0:       return 8'($urandom_range(COLUMNS - 4, COLUMNS - 1));
            1:       return 8'($urandom_range(0, 255));
            default: return 8'($urandom_range(0, COLUMNS - 1));
        endcase
    endfunction

    function automatic logic [7:0] rand_x();
        return ($urandom_range(0, 9) == 0) ? 8'($urandom_range(COLUMNS, 255))
                                           : 8'($urandom_range(0, COLUMNS - 1));
    endfunction

    function automatic logic [7:0] rand_y();
        return ($urandom_range(0, 9) == 0) ? 8'($urandom_range(ROWS, 255))
                                           : 8'($urandom_range(0, ROWS - 1));
    endfunction

    function automatic logic [7:0] rand_instruction();
        logic [7:0] mode_pair [5] = '{plcd_pkg::INS_ADC, plcd_pkg::INS_BIAS,
                                      plcd_pkg::INS_ENTIRE, plcd_pkg::INS_REVERSE,
                                      plcd_pkg::INS_ON};
        case ($urandom_range(0, 11))
            0:       return 8'(plcd_pkg::INS_COL_LO + $urandom_range(0, 15));
            1:       return 8'(plcd_pkg::INS_COL_HI + $urandom_range(0, 15));
            2:       return plcd_pkg::INS_PAGE + {4'h0, rand_page()};
            3:       return 8'($urandom_range(plcd_pkg::INS_REGULATOR, plcd_pkg::INS_POWER_LAST));
            4:       return 8'($urandom_range(plcd_pkg::INS_START, plcd_pkg::INS_START_LAST));
            5, 6:    return mode_pair[$urandom_range(0, 4)] | 8'($urandom_range(0, 1));
            7:       return 8'($urandom_range(plcd_pkg::INS_SHL, plcd_pkg::INS_SHL_LAST));
            8:       return $urandom_range(0, 1) ? plcd_pkg::INS_MODIFY_SET
                                                 : plcd_pkg::INS_MODIFY_RESET;
            9:       return plcd_pkg::INS_SOFT_RESET;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // Edge cases first: pixel corners, dummy reads, saturation, modify-read,
    // two-byte commands, status bits, addresses outside memory, soft reset.
    task automatic run_directed();
        send_status();
        send_pixel(8'd0, 8'd0, plcd_pkg::POP_SET);
        send_pixel(8'd0, 8'd1, plcd_pkg::POP_SET);
        send_pixel(8'd0, 8'd0, POP_CLEAR);
        send_pixel(8'(COLUMNS - 1), 8'(ROWS - 1), plcd_pkg::POP_INVERT);
        send_pixel(8'(COLUMNS), 8'd0, plcd_pkg::POP_SET);
        send_pixel(8'd0, 8'(ROWS), plcd_pkg::POP_INVERT);
        send_pixel(8'hFF, 8'hFF, POP_CLEAR_ALT);
        send_read();
        send_read();
        // Two writes at the last column; the second lands on the same byte.
        set_address(4'(PAGES - 1), 8'(COLUMNS - 1));
        send_data(8'h5A);
        send_data(8'hA5);
        send_instr(plcd_pkg::INS_MODIFY_SET);
        send_read();
        send_read();
        send_instr(plcd_pkg::INS_MODIFY_RESET);
        send_instr(plcd_pkg::INS_MODIFY_RESET);
        // The soft reset byte is consumed as the reference level here.
        send_instr(plcd_pkg::INS_REF_LEVEL);
        send_instr(plcd_pkg::INS_SOFT_RESET);
        send_instr(plcd_pkg::INS_ADC_LAST);
        send_instr(plcd_pkg::INS_ON_LAST);
        send_status();
        send_instr(plcd_pkg::INS_PAGE_LAST);
        send_data(8'hFF);
        send_read();
        send_read();
        send_instr(plcd_pkg::INS_SOFT_RESET);
        send_status();
        send_access(3'($urandom_range(CMD_UNDEF_FIRST, CMD_UNDEF_LAST)),
                    8'($urandom), 8'($urandom), 8'($urandom), 2'($urandom));
    endtask

    // Random traffic built mostly from well-formed access sequences.
    task automatic run_random(int unsigned count);
        int unsigned stop;
        logic [7:0]  px;
        logic [7:0]  py;
        logic [3:0]  pg;
        stop = sent + count;
        while (sent < stop) begin
            case ($urandom_range(0, 11))
                0, 1: begin
                    set_address(rand_page(), rand_column());
                    repeat ($urandom_range(1, 16)) send_data(8'($urandom_range(0, 255)));
                end
                2, 3: begin
                    set_address(rand_page(), rand_column());
                    repeat ($urandom_range(2, 16)) send_read();
                end
                4: begin
                    set_address(rand_page(), rand_column());
                    send_instr(plcd_pkg::INS_MODIFY_SET);
                    repeat ($urandom_range(1, 6)) begin
                        send_read();
                        send_read();
                        send_data(8'($urandom_range(0, 255)));
                    end
                    send_instr(plcd_pkg::INS_MODIFY_RESET);
                    send_read();
                end
                5, 6: begin
                    repeat ($urandom_range(1, 12))
                        send_pixel(rand_x(), rand_y(), 2'($urandom_range(0, 3)));
                    // Read back the byte that one in-range pixel touched.
                    if ($urandom_range(0, 1)) begin
                        px = 8'($urandom_range(0, COLUMNS - 1));
                        py = 8'($urandom_range(0, ROWS - 1));
                        pg = py[6:3];
                        send_pixel(px, py, 2'($urandom_range(0, 3)));
                        set_address(pg, px);
                        send_read();
                        send_read();
                    end
                end
                7: begin
                    send_instr($urandom_range(0, 1) ? plcd_pkg::INS_REF_LEVEL
                               : ($urandom_range(0, 1) ? plcd_pkg::INS_INDICATOR
                                                       : plcd_pkg::INS_INDICATOR_LAST));
                    send_instr(8'($urandom_range(0, 255)));
                end
                8, 9: begin
                    repeat ($urandom_range(1, 4)) send_instr(rand_instruction());
                    send_status();
                end
                default: begin
                    repeat ($urandom_range(1, 4))
                        send_access(3'($urandom_range(0, 7)), 8'($urandom), 8'($urandom),
                                    8'($urandom), 2'($urandom));
                end
            endcase
        end
    endtask

    // Stimulus sequence and final verdict.
    initial begin
        sent          = 0;
        send_idle_pct = 13;
        recv_idle_pct = 46;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        run_directed();
        run_random(PHASE_ITEMS);
        drain();

        send_idle_pct = 46;
        recv_idle_pct = 13;
        run_random(PHASE_ITEMS);
        drain();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_random(PHASE_ITEMS);
        drain();
        repeat (16) @(posedge aclk);

        $display("Run covered %0d accesses: %0d instruction writes, %0d data writes, %0d reads,",
                 sb.accepted, sb.per_cmd[plcd_pkg::CMD_WRITE_INSTR],
                 sb.per_cmd[plcd_pkg::CMD_WRITE_DATA], sb.per_cmd[plcd_pkg::CMD_READ_DATA]);
        $display("%0d status reads, %0d pixel ops (%0d out of range), %0d undefined; %0d checked.",
                 sb.per_cmd[plcd_pkg::CMD_READ_STATUS], sb.per_cmd[plcd_pkg::CMD_PIXEL],
                 sb.pixel_errors, sb.undefined_cmds, sb.checked);
        if (sb.mismatches == 0) begin
            $display("page_lcd_controller_pixel_rmw verification clean");
        end else begin
            $display("%0d mismatches found.", sb.mismatches);
            $display("page_lcd_controller_pixel_rmw verification failed");
        end
        $finish;
    end

endmodule
